### design/kvt_pkg.sv
// Shared types and constants for the key/value line tokenizer.
// Used by the front, back and top modules; depends on nothing.
package kvt_pkg;

	localparam int CNT_W = 7;   // holds a space count up to 127
	localparam int TOK_W = 6;

	localparam logic [2:0] CFG_ASSIGN  = 3'd0;
	localparam logic [2:0] CFG_COMMENT = 3'd1;
	localparam logic [2:0] CFG_ESCAPE  = 3'd2;
	localparam logic [2:0] CFG_DELIM_A = 3'd3;
	localparam logic [2:0] CFG_DELIM_B = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_ASSIGN = 3'd1;
	localparam logic [2:0] ST_MULTI     = 3'd2;
	localparam logic [2:0] ST_SPACE_OVF = 3'd3;
	localparam logic [2:0] ST_TOO_MANY  = 3'd4;

	localparam logic [7:0] RST_ASSIGN  = 8'd61;
	localparam logic [7:0] RST_COMMENT = 8'd35;
	localparam logic [7:0] RST_ESCAPE  = 8'd92;
	localparam logic [7:0] RST_DELIM_A = 8'd44;
	localparam logic [7:0] RST_DELIM_B = 8'd59;

	typedef enum logic [2:0] {
		CMD_SPACE,  // store a held whitespace byte at index cnt
		CMD_EMIT,   // send cnt held bytes, then the character
		CMD_FLUSH,  // send cnt held bytes only
		CMD_TEND,   // token end marker
		CMD_LEND    // line end marker with status
	} cmd_op_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_FLUSH,
		B_TAIL
	} back_state_t;

	typedef struct packed {
		cmd_op_t          op;
		logic [7:0]       ch;
		logic [TOK_W-1:0] token;
		logic [CNT_W-1:0] cnt;
		logic [2:0]       status;
	} cmd_t;

	typedef struct packed {
		logic [7:0]       ch;
		logic             valid;
		logic [TOK_W-1:0] token;
		logic             tend;
		logic             lend;
		logic [2:0]       status;
	} result_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

endpackage

### design/kvt_queue.sv
// Small register queue used between front and back and on the result side.
// Stand-alone; no package content needed.
module kvt_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign dout  = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) data_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)      count_q <= count_q + 1'b1;
			else if (!do_wr && do_rd) count_q <= count_q - 1'b1;
		end
	end
endmodule

### design/kvt_front.sv
// Front end: configuration registers, line parsing state and classification.
// Turns each accepted item into at most one command for the back end. Uses kvt_pkg.
module kvt_front import kvt_pkg::*; #(
	parameter int SPACE_DEPTH = 16,
	parameter int MAX_TOKENS  = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       line_done,
	input  logic       wr_en,
	input  logic [2:0] wr_index,
	input  logic [7:0] wr_data,
	output logic       cmd_push,
	output cmd_t       cmd,
	input  logic       cmd_full
);
	localparam logic [CNT_W-1:0] SPC_MAX  = CNT_W'(SPACE_DEPTH);
	localparam logic [TOK_W-1:0] TOK_LAST = TOK_W'(MAX_TOKENS - 1);

	logic [7:0] assign_q, comment_q, escape_q, delim_a_q, delim_b_q;

	logic             esc_q, esc_d;
	logic             cmt_q, cmt_d;
	logic [1:0]       asg_q, asg_d;
	logic [TOK_W-1:0] tok_q, tok_d;
	logic             lead_q, lead_d;
	logic [CNT_W-1:0] spc_q, spc_d;
	logic             ovf_q, ovf_d;
	logic             vovf_q, vovf_d;
	logic             accept;
	logic             is_delim;

	assign full     = cmd_full;
	assign accept   = push && !cmd_full;
	assign is_delim = (in_byte == delim_a_q) || (in_byte == delim_b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assign_q  <= RST_ASSIGN;
			comment_q <= RST_COMMENT;
			escape_q  <= RST_ESCAPE;
			delim_a_q <= RST_DELIM_A;
			delim_b_q <= RST_DELIM_B;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_ASSIGN:  assign_q  <= wr_data;
				CFG_COMMENT: comment_q <= wr_data;
				CFG_ESCAPE:  escape_q  <= wr_data;
				CFG_DELIM_A: delim_a_q <= wr_data;
				CFG_DELIM_B: delim_b_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		esc_d      = esc_q;
		cmt_d      = cmt_q;
		asg_d      = asg_q;
		tok_d      = tok_q;
		lead_d     = lead_q;
		spc_d      = spc_q;
		ovf_d      = ovf_q;
		vovf_d     = vovf_q;
		cmd_push   = 1'b0;
		cmd.op     = CMD_EMIT;
		cmd.ch     = in_byte;
		cmd.token  = tok_q;
		cmd.cnt    = spc_q;
		cmd.status = ST_OK;
		if (accept) begin
			if (line_done) begin
				cmd_push = 1'b1;
				cmd.op   = CMD_LEND;
				if (asg_q == 2'd0)      cmd.status = ST_NO_ASSIGN;
				else if (asg_q == 2'd2) cmd.status = ST_MULTI;
				else if (ovf_q)         cmd.status = ST_SPACE_OVF;
				else if (vovf_q)        cmd.status = ST_TOO_MANY;
				esc_d  = 1'b0;
				cmt_d  = 1'b0;
				asg_d  = 2'd0;
				tok_d  = '0;
				lead_d = 1'b1;
				spc_d  = '0;
				ovf_d  = 1'b0;
				vovf_d = 1'b0;
			end else if (cmt_q) begin
				// rest of line is comment
			end else if (esc_q) begin
				cmd_push = 1'b1;
				esc_d    = 1'b0;
				spc_d    = '0;
				lead_d   = 1'b0;
			end else if (in_byte == escape_q) begin
				// held whitespace goes out now; the escape itself is dropped
				cmd_push = (spc_q != '0);
				cmd.op   = CMD_FLUSH;
				esc_d    = 1'b1;
				spc_d    = '0;
				lead_d   = 1'b0;
			end else if (in_byte == comment_q) begin
				cmt_d = 1'b1;
			end else if (in_byte == assign_q && asg_q == 2'd0) begin
				cmd_push = 1'b1;
				cmd.op   = CMD_TEND;
				asg_d    = 2'd1;
				spc_d    = '0;
				lead_d   = 1'b1;
				tok_d    = TOK_W'(1);
			end else begin
				if (in_byte == assign_q) asg_d = 2'd2;
				if (asg_q != 2'd0 && is_delim) begin
					cmd_push = 1'b1;
					cmd.op   = CMD_TEND;
					spc_d    = '0;
					lead_d   = 1'b1;
					if (tok_q < TOK_LAST) tok_d = tok_q + 1'b1;
					else                  vovf_d = 1'b1;
				end else if (is_space(in_byte)) begin
					if (!lead_q) begin
						if (spc_q < SPC_MAX) begin
							cmd_push = 1'b1;
							cmd.op   = CMD_SPACE;
							spc_d    = spc_q + 1'b1;
						end else begin
							ovf_d = 1'b1;
						end
					end
				end else begin
					cmd_push = 1'b1;
					spc_d    = '0;
					lead_d   = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b0;
			cmt_q  <= 1'b0;
			asg_q  <= 2'd0;
			tok_q  <= '0;
			lead_q <= 1'b1;
			spc_q  <= '0;
			ovf_q  <= 1'b0;
			vovf_q <= 1'b0;
		end else begin
			esc_q  <= esc_d;
			cmt_q  <= cmt_d;
			asg_q  <= asg_d;
			tok_q  <= tok_d;
			lead_q <= lead_d;
			spc_q  <= spc_d;
			ovf_q  <= ovf_d;
			vovf_q <= vovf_d;
		end
	end
endmodule

### design/kvt_back.sv
// Back end: whitespace holding memory and result sequencing.
// Executes front commands one at a time into the result queue. Uses kvt_pkg.
module kvt_back import kvt_pkg::*; #(
	parameter int SPACE_DEPTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  logic    cmd_empty,
	output logic    cmd_pop,
	output result_t res,
	output logic    res_push,
	input  logic    res_full
);
	localparam int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

	back_state_t      state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d, idx_next;
	cmd_t             cmd_q;
	logic             load_cmd;
	logic [7:0]       space_mem_q [SPACE_DEPTH];
	logic [7:0]       rdata_q;
	logic             mem_we, rd_en;
	logic [AW-1:0]    rd_addr;

	assign idx_next = idx_q + 1'b1;

	always_ff @(posedge clk) begin
		if (mem_we) space_mem_q[cmd.cnt[AW-1:0]] <= cmd.ch;
		if (rd_en)  rdata_q <= space_mem_q[rd_addr];
		if (load_cmd) cmd_q <= cmd;
	end

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		mem_we   = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = idx_q[AW-1:0];
		load_cmd = 1'b0;
		res      = '0;
		res.token = cmd.token;
		unique case (state_q)
			B_IDLE: begin
				if (!cmd_empty) begin
					unique case (cmd.op)
						CMD_SPACE: begin
							cmd_pop = 1'b1;
							mem_we  = 1'b1;
						end
						CMD_EMIT, CMD_FLUSH: begin
							if (cmd.cnt != '0) begin
								// first read issued now, data lands next cycle
								cmd_pop  = 1'b1;
								load_cmd = 1'b1;
								rd_en    = 1'b1;
								rd_addr  = '0;
								idx_d    = '0;
								state_d  = B_FLUSH;
							end else if (cmd.op == CMD_FLUSH) begin
								cmd_pop = 1'b1;
							end else if (!res_full) begin
								cmd_pop   = 1'b1;
								res_push  = 1'b1;
								res.ch    = cmd.ch;
								res.valid = 1'b1;
							end
						end
						CMD_TEND, CMD_LEND: begin
							if (!res_full) begin
								cmd_pop    = 1'b1;
								res_push   = 1'b1;
								res.tend   = 1'b1;
								res.lend   = (cmd.op == CMD_LEND);
								res.status = cmd.status;
							end
						end
						default: ;
					endcase
				end
			end
			B_FLUSH: begin
				res.token = cmd_q.token;
				if (!res_full) begin
					res_push  = 1'b1;
					res.ch    = rdata_q;
					res.valid = 1'b1;
					if (idx_next < cmd_q.cnt) begin
						rd_en   = 1'b1;
						rd_addr = idx_next[AW-1:0];
						idx_d   = idx_next;
					end else begin
						state_d = (cmd_q.op == CMD_EMIT) ? B_TAIL : B_IDLE;
					end
				end
			end
			B_TAIL: begin
				res.token = cmd_q.token;
				if (!res_full) begin
					res_push  = 1'b1;
					res.ch    = cmd_q.ch;
					res.valid = 1'b1;
					state_d   = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end
endmodule

### design/key_value_line_tokenizer.sv
// Top level of the key/value line tokenizer: front parser, command queue,
// back end with whitespace memory, and result queue. Uses kvt_pkg and all kvt_ modules.
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------------
//   input   | push / full           | in_byte, line_done
//   result  | empty / pop           | out_char, char_valid, token_index, token_end,
//           |                       | line_end, line_status
//   config  | wr_en (no wait)       | wr_index, wr_data
//
// The front takes one item per cycle while the two-entry command queue has room.
// The back executes one command at a time and stalls while the result queue is full;
// a character that follows held whitespace bytes goes out after them through the
// single read port of the whitespace memory (one byte per cycle while the result queue has room, read data registered).
// Reset is asynchronous and needs no clearing pass; stale memory entries are never read.
// Each side stalls on its own: full follows the command queue, empty the result queue.
module key_value_line_tokenizer import kvt_pkg::*; #(
	parameter int SPACE_DEPTH = 16,
	parameter int MAX_TOKENS  = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       line_done,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       char_valid,
	output logic [5:0] token_index,
	output logic       token_end,
	output logic       line_end,
	output logic [2:0] line_status,
	input  logic       wr_en,
	input  logic [2:0] wr_index,
	input  logic [7:0] wr_data
);
	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(result_t);

	cmd_t       cmd_in, cmd_out;
	logic       cmd_push, cmd_full, cmd_pop, cmd_empty;
	logic [CMD_W-1:0] cmd_dout;
	result_t    res_in, res_out;
	logic       res_push, res_full;
	logic [RES_W-1:0] res_dout;

	kvt_front #(
		.SPACE_DEPTH(SPACE_DEPTH),
		.MAX_TOKENS (MAX_TOKENS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_byte  (in_byte),
		.line_done(line_done),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	kvt_queue #(
		.WIDTH(CMD_W),
		.DEPTH(2)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (cmd_push),
		.din   (cmd_in),
		.full  (cmd_full),
		.rd    (cmd_pop),
		.dout  (cmd_dout),
		.empty (cmd_empty)
	);

	assign cmd_out = cmd_t'(cmd_dout);

	kvt_back #(
		.SPACE_DEPTH(SPACE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_out),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res      (res_in),
		.res_push (res_push),
		.res_full (res_full)
	);

	kvt_queue #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.din   (res_in),
		.full  (res_full),
		.rd    (pop),
		.dout  (res_dout),
		.empty (empty)
	);

	assign res_out     = result_t'(res_dout);
	assign out_char    = res_out.ch;
	assign char_valid  = res_out.valid;
	assign token_index = res_out.token;
	assign token_end   = res_out.tend;
	assign line_end    = res_out.lend;
	assign line_status = res_out.status;
endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for key_value_line_tokenizer: directed and random
// settings lines under three register settings, checked result by result.
// Depends on kvt_pkg and the tokenizer RTL only.

module tb_top;
	import kvt_pkg::*;

	localparam int SPACE_DEPTH  = 16;
	localparam int MAX_TOKENS   = 64;
	// margin for the back end to flush held whitespace, two commands queued
	localparam int DRAIN_CYCLES = 3 * SPACE_DEPTH + 16;
	localparam int HOLD_CYCLES  = 300;
	// longest quiet stretch is the receiver hold plus a flush; keep a wide margin
	localparam int STALL_LIMIT  = 4000;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       push      = 1'b0;
	logic [7:0] in_byte   = 8'h00;
	logic       line_done = 1'b0;
	logic       pop       = 1'b0;
	logic       wr_en     = 1'b0;
	logic [2:0] wr_index  = CFG_ASSIGN;
	logic [7:0] wr_data   = 8'h00;
	logic       full;
	logic       empty;
	logic [7:0] out_char;
	logic       char_valid;
	logic [5:0] token_index;
	logic       token_end;
	logic       line_end;
	logic [2:0] line_status;

	key_value_line_tokenizer #(
		.SPACE_DEPTH(SPACE_DEPTH),
		.MAX_TOKENS (MAX_TOKENS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_byte    (in_byte),
		.line_done  (line_done),
		.empty      (empty),
		.pop        (pop),
		.out_char   (out_char),
		.char_valid (char_valid),
		.token_index(token_index),
		.token_end  (token_end),
		.line_end   (line_end),
		.line_status(line_status),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data)
	);

	// register copy and line state of the tokenizer
	logic [7:0] cfg_assign  = RST_ASSIGN;
	logic [7:0] cfg_comment = RST_COMMENT;
	logic [7:0] cfg_escape  = RST_ESCAPE;
	logic [7:0] cfg_delim_a = RST_DELIM_A;
	logic [7:0] cfg_delim_b = RST_DELIM_B;
	bit         esc_pend;
	bit         in_cmt;
	bit         lead = 1'b1;
	bit         ws_ovf;
	bit         val_ovf;
	int         n_assigns;
	logic [5:0] tok_idx;
	logic [7:0] held_q[$];
	result_t    tok_exp_q[$];

	logic [7:0] line_q[$];
	int         n_items;
	int         n_lines;
	int         n_results;
	int         n_errors;
	int         send_idle_pct;
	int         recv_idle_pct;
	bit         hold_req;
	int         hold_left;
	int         stall_count;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit is_blank(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function void add_result(logic [7:0] ch, logic vld, logic te, logic le, logic [2:0] st);
		result_t r;
		r.ch     = ch;
		r.valid  = vld;
		r.token  = tok_idx;
		r.tend   = te;
		r.lend   = le;
		r.status = st;
		tok_exp_q.push_back(r);
	endfunction

	function void flush_held();
		foreach (held_q[i])
			add_result(held_q[i], 1'b1, 1'b0, 1'b0, ST_OK);
		held_q.delete();
	endfunction

	function void close_token();
		add_result(8'h00, 1'b0, 1'b1, 1'b0, ST_OK);
		held_q.delete();
		lead = 1'b1;
	endfunction

	function void clear_line();
		esc_pend  = 1'b0;
		in_cmt    = 1'b0;
		n_assigns = 0;
		tok_idx   = '0;
		lead      = 1'b1;
		ws_ovf    = 1'b0;
		val_ovf   = 1'b0;
		held_q.delete();
	endfunction

	// expected results of one accepted item
	function void tokenize_step(logic [7:0] c, logic done);
		logic [2:0] st;
		if (done) begin
			if (n_assigns == 0)
				st = ST_NO_ASSIGN;
			else if (n_assigns >= 2)
				st = ST_MULTI;
			else if (ws_ovf)
				st = ST_SPACE_OVF;
			else if (val_ovf)
				st = ST_TOO_MANY;
			else
				st = ST_OK;
			add_result(8'h00, 1'b0, 1'b1, 1'b1, st);
			clear_line();
			n_lines++;
			return;
		end
		if (in_cmt)
			return;
		if (esc_pend) begin
			esc_pend = 1'b0;
			flush_held();
			lead = 1'b0;
			add_result(c, 1'b1, 1'b0, 1'b0, ST_OK);
			return;
		end
		if (c == cfg_escape) begin
			// held whitespace goes out ahead of the escaped character
			esc_pend = 1'b1;
			flush_held();
			lead = 1'b0;
			return;
		end
		if (c == cfg_comment) begin
			in_cmt = 1'b1;
			return;
		end
		if (c == cfg_assign) begin
			if (n_assigns == 0) begin
				n_assigns = 1;
				close_token();
				tok_idx = 6'd1;
				return;
			end
			// later assigns only count, then fall through as delimiter or text
			n_assigns = 2;
		end
		if (n_assigns != 0 && (c == cfg_delim_a || c == cfg_delim_b)) begin
			close_token();
			if (tok_idx < MAX_TOKENS - 1)
				tok_idx++;
			else
				val_ovf = 1'b1;
			return;
		end
		if (is_blank(c)) begin
			if (!lead) begin
				if (held_q.size() < SPACE_DEPTH)
					held_q.push_back(c);
				else
					ws_ovf = 1'b1;
			end
			return;
		end
		flush_held();
		lead = 1'b0;
		add_result(c, 1'b1, 1'b0, 1'b0, ST_OK);
	endfunction

	task automatic send_item(logic [7:0] c, logic done);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		in_byte   <= c;
		line_done <= done;
		@(posedge clk);
		while (full) @(posedge clk);
		tokenize_step(c, done);
		n_items++;
	endtask

	task automatic send_eol();
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	task automatic send_line();
		foreach (line_q[i])
			send_item(line_q[i], 1'b0);
		send_eol();
	endtask

	// wait until every expected result is out and the back end has gone quiet
	task automatic drain();
		push <= 1'b0;
		while (tok_exp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// wr_en stays high across the five writes
	task automatic load_registers(logic [7:0] a, logic [7:0] cm, logic [7:0] esc,
			logic [7:0] da, logic [7:0] db);
		wr_en    <= 1'b1;
		wr_index <= CFG_ASSIGN;
		wr_data  <= a;
		@(posedge clk);
		cfg_assign = a;
		wr_index <= CFG_COMMENT;
		wr_data  <= cm;
		@(posedge clk);
		cfg_comment = cm;
		wr_index <= CFG_ESCAPE;
		wr_data  <= esc;
		@(posedge clk);
		cfg_escape = esc;
		wr_index <= CFG_DELIM_A;
		wr_data  <= da;
		@(posedge clk);
		cfg_delim_a = da;
		wr_index <= CFG_DELIM_B;
		wr_data  <= db;
		@(posedge clk);
		cfg_delim_b = db;
		wr_en <= 1'b0;
	endtask

	function automatic bit is_marker(logic [7:0] c);
		return c == cfg_assign || c == cfg_comment || c == cfg_escape ||
			c == cfg_delim_a || c == cfg_delim_b;
	endfunction

	function automatic logic [7:0] pick_blank();
		logic [7:0] b;
		b = 8'($urandom_range(8'h09, 8'h0E));
		return (b == 8'h0E) ? 8'h20 : b;
	endfunction

	function automatic logic [7:0] pick_plain();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (is_marker(c) || is_blank(c));
		return c;
	endfunction

	function automatic logic [7:0] pick_any();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return pick_plain();
		if (r < 50) return pick_blank();
		if (r < 60) return cfg_assign;
		if (r < 66) return cfg_delim_a;
		if (r < 72) return cfg_delim_b;
		if (r < 78) return cfg_escape;
		if (r < 81) return cfg_comment;
		return 8'($urandom_range(0, 255));
	endfunction

	function void add_blanks(int hi);
		int n;
		// now and then a run long enough to overflow the held whitespace
		n = ($urandom_range(0, 99) < 8) ? $urandom_range(SPACE_DEPTH - 2, SPACE_DEPTH + 4)
			: $urandom_range(0, hi);
		repeat (n) line_q.push_back(pick_blank());
	endfunction

	function void add_word();
		int r;
		repeat ($urandom_range(1, 4)) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				line_q.push_back(pick_plain());
			end else if (r < 82) begin
				line_q.push_back(pick_blank());
			end else if (r < 92) begin
				line_q.push_back(cfg_escape);
				line_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				line_q.push_back(pick_any());
			end
		end
	endfunction

	function void build_kv_line();
		int nv;
		line_q.delete();
		add_blanks(2);
		add_word();
		add_blanks(2);
		line_q.push_back(cfg_assign);
		nv = $urandom_range(0, 4);
		for (int i = 0; i < nv; i++) begin
			if (i > 0)
				line_q.push_back($urandom_range(0, 1) ? cfg_delim_a : cfg_delim_b);
			add_blanks(2);
			add_word();
			add_blanks(3);
		end
		if ($urandom_range(0, 99) < 15) begin
			line_q.push_back(cfg_comment);
			repeat ($urandom_range(0, 3)) line_q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	function void build_noise_line();
		line_q.delete();
		repeat ($urandom_range(0, 12)) line_q.push_back(pick_any());
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			n_errors++;
			if (n_errors <= 40)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	task automatic check_result();
		result_t want;
		n_results++;
		if (tok_exp_q.size() == 0) begin
			n_errors++;
			if (n_errors <= 40)
				$display("%0t: unexpected result, expected none, got char %02h tend %b lend %b",
					$time, out_char, token_end, line_end);
			return;
		end
		want = tok_exp_q.pop_front();
		check_field("out_char", want.ch, out_char);
		check_field("char_valid", 8'(want.valid), 8'(char_valid));
		check_field("token_index", 8'(want.token), 8'(token_index));
		check_field("token_end", 8'(want.tend), 8'(token_end));
		check_field("line_end", 8'(want.lend), 8'(line_end));
		check_field("line_status", 8'(want.status), 8'(line_status));
	endtask

	// result side: check on accept, then pick pop for the next edge
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			check_result();
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			stall_count = 0;
		else
			stall_count++;
		if (stall_count >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, stall_count);
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic test_directed_lines();
		// leading blank, delimiter in key, escaped assign, held inner blank,
		// trailing lone escape
		send_text(" k,\\=y = a b ;c\\");
		send_eol();
		// second assign is plain text, comment drops the tail
		send_text("x=1=2#z");
		send_eol();
		// no assign, byte extremes, blanks dropped at the line end
		send_item(8'h00, 1'b0);
		send_item(8'h09, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h0D, 1'b0);
		send_item(8'h0C, 1'b0);
		send_eol();
		send_eol();
		// leading blank before an escape is dropped; escaped blank is text, a later blank is held
		send_text("a=\n\\ \vb");
		send_eol();
	endtask

	task automatic test_limits();
		send_text("k=a");
		repeat (SPACE_DEPTH + 4) send_item(8'h20, 1'b0);
		send_text("b");
		send_eol();
		send_text("k=");
		repeat (MAX_TOKENS) send_item(cfg_delim_a, 1'b0);
		send_text("z");
		send_eol();
	endtask

	task automatic test_full_stall();
		int stop_at;
		stop_at = n_items + 20;
		send_idle_pct = 0;
		hold_req = 1'b1;
		while (n_items < stop_at) begin
			build_kv_line();
			send_line();
		end
		send_idle_pct = 18;
	endtask

	task automatic test_random_lines(int target);
		int stop_at;
		stop_at = n_items + target;
		while (n_items < stop_at) begin
			if ($urandom_range(0, 99) < 75)
				build_kv_line();
			else
				build_noise_line();
			send_line();
		end
	endtask

	initial begin
		send_idle_pct = 18;
		recv_idle_pct = 48;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_lines();
		drain();
		test_limits();
		drain();
		test_full_stall();
		drain();
		test_random_lines(10);
		drain();
		send_idle_pct = 48;
		recv_idle_pct = 18;
		// assign shares its code with a delimiter; escape is the space
		load_registers(8'h00, 8'hFF, 8'h20, 8'h00, 8'h09);
		test_random_lines(10);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_registers(8'hFF, 8'h00, 8'h7F, 8'h80, 8'hFF);
		test_random_lines(10);
		drain();
		$display("summary: %0d items in %0d lines, %0d results compared", n_items, n_lines,
			n_results);
		$display("summary: three register sets, limit cases and a full-queue stall");
		if (n_errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
